// ===== rtl/skl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skl_pkg: shared types and constants
// FNV-1a constants, field widths, register indexes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package skl_pkg;

	localparam int SEQ_W   = 32;
	localparam int HASH_W  = 32;
	localparam int LEVEL_W = 6;
	localparam int RATIO_W = 8;
	localparam int CNT_W   = 4;

	localparam logic [HASH_W-1:0]  FNV_BASIS = 32'h811C_9DC5;
	localparam logic [HASH_W-1:0]  FNV_PRIME = 32'h0100_0193;
	localparam logic [7:0]         BYTE_MASK = 8'hFF;

	localparam logic [LEVEL_W-1:0] LIMIT_RESET = 6'd12;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd4;
	localparam logic [RATIO_W-1:0] RATIO_MIN   = 8'd2;

	localparam logic CFG_IDX_LIMIT = 1'b0;
	localparam logic CFG_IDX_RATIO = 1'b1;

	localparam logic [CNT_W-1:0] CNT_HASH_LAST = 4'd3;
	localparam logic [CNT_W-1:0] CNT_DIV_LAST  = 4'd15;

	typedef struct packed {
		logic load;
		logic hash_step;
		logic div_load;
		logic div_step;
		logic level_up;
		logic out_load;
	} skl_cmd_t;

	typedef struct packed {
		logic cfg_bad;
		logic below_limit;
		logic rem_zero;
	} skl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/skiplist_height_from_hash_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skiplist_height_from_hash_core: skip list level from a sequence number
// Sequence: load, hash rounds, then per level a limit check and a radix-4
//   divider pass; a bad configuration goes straight to the result.
// Flow: one item at a time; a new sequence number is taken only after the
//   previous result has been handed to the output register.
// Reset: arst_n clears the controller and output valid; limit 12, ratio 4.
// ----------------------------------------------------------------------------
module skiplist_height_from_hash_core import skl_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [SEQ_W-1:0]   sequence_number,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [LEVEL_W-1:0]      node_level,
	output logic                    config_error,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [RATIO_W-1:0] cfg_data
);

	logic [LEVEL_W-1:0] height_limit_q;
	logic [RATIO_W-1:0] branch_ratio_q;
	skl_cmd_t           cmd;
	skl_sts_t           sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_limit_q <= LIMIT_RESET;
			branch_ratio_q <= RATIO_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_IDX_LIMIT) begin
				height_limit_q <= cfg_data[LEVEL_W-1:0];
			end
			if (cfg_index == CFG_IDX_RATIO) begin
				branch_ratio_q <= cfg_data;
			end
		end
	end

	skl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	skl_dp u_dp (
		.clk             (clk),
		.cmd             (cmd),
		.sequence_number (sequence_number),
		.height_limit    (height_limit_q),
		.branch_ratio    (branch_ratio_q),
		.sts             (sts),
		.node_level      (node_level),
		.config_error    (config_error)
	);

	a_err_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && config_error |-> node_level == '0)
		else $error("error result carries a nonzero level");

	a_ok_level_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !config_error |-> node_level != '0)
		else $error("valid result has level zero");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

endmodule
`default_nettype wire

// ===== rtl/skl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skl_ctrl: sequencing controller
// Steps the datapath through four hash rounds, then one radix-4 division
// pass per level, and hands the result to the output register.
// ----------------------------------------------------------------------------
module skl_ctrl import skl_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire skl_sts_t sts,
	output skl_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HASH  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_STEP  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;
	logic             out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = sts.cfg_bad ? S_DONE : S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				cnt_d         = cnt_q + 4'd1;
				if (cnt_q == CNT_HASH_LAST) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cnt_d = '0;
				if (sts.below_limit) begin
					cmd.div_load = 1'b1;
					state_d      = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 4'd1;
				if (cnt_q == CNT_DIV_LAST) begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				if (sts.rem_zero) begin
					cmd.level_up = 1'b1;
					state_d      = S_CHECK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/skl_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skl_dp: hash and division datapath
// FNV-1a round unit (one byte a cycle), two-bit-per-cycle restoring divider,
// level counter and the output register.
// ----------------------------------------------------------------------------
module skl_dp import skl_pkg::*; (
	input  wire logic               clk,
	input  wire skl_cmd_t           cmd,
	input  wire logic [SEQ_W-1:0]   sequence_number,
	input  wire logic [LEVEL_W-1:0] height_limit,
	input  wire logic [RATIO_W-1:0] branch_ratio,
	output skl_sts_t                sts,
	output logic [LEVEL_W-1:0]      node_level,
	output logic                    config_error
);

	logic [SEQ_W-1:0]   seq_q;
	logic [HASH_W-1:0]  acc_q;
	logic [HASH_W-1:0]  quo_q;
	logic [RATIO_W-1:0] rem_q;
	logic [LEVEL_W-1:0] level_q;
	logic               err_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic               out_err_q;

	logic [HASH_W-1:0]   mix;
	logic [HASH_W-1:0]   prod;
	logic [RATIO_W:0]    st1, st2;

	function automatic logic [RATIO_W:0] div_bit(input logic [RATIO_W-1:0] r,
		input logic b, input logic [RATIO_W-1:0] d);
		logic [RATIO_W:0] t;
		logic [RATIO_W:0] diff;
		t    = {r, b};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			div_bit = {diff[RATIO_W-1:0], 1'b1};
		end else begin
			div_bit = {r[RATIO_W-2:0], b, 1'b0};
		end
	endfunction

	assign mix  = acc_q ^ {24'd0, seq_q[7:0] & BYTE_MASK};
	assign prod = mix * FNV_PRIME;
	assign st1  = div_bit(rem_q, quo_q[HASH_W-1], branch_ratio);
	assign st2  = div_bit(st1[RATIO_W:1], quo_q[HASH_W-2], branch_ratio);

	assign sts.cfg_bad     = (height_limit == '0) || (branch_ratio < RATIO_MIN);
	assign sts.below_limit = (level_q < height_limit);
	assign sts.rem_zero    = (rem_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q   <= sequence_number;
			acc_q   <= FNV_BASIS;
			err_q   <= sts.cfg_bad;
			level_q <= sts.cfg_bad ? 6'd0 : 6'd1;
		end
		if (cmd.hash_step) begin
			acc_q <= prod;
			seq_q <= {8'd0, seq_q[SEQ_W-1:8]};
		end
		if (cmd.div_load) begin
			quo_q <= acc_q;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[HASH_W-3:0], st1[0], st2[0]};
			rem_q <= st2[RATIO_W:1];
		end
		if (cmd.level_up) begin
			acc_q   <= quo_q;
			level_q <= level_q + 6'd1;
		end
		if (cmd.out_load) begin
			out_level_q <= level_q;
			out_err_q   <= err_q;
		end
	end

	assign node_level   = out_level_q;
	assign config_error = out_err_q;

endmodule
`default_nettype wire

// ===== bench/skiplist_height_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skiplist_height_checker: level predictor and result scoreboard
// Watches the input, result and register channels of the skip list level
// core. Each accepted sequence number is hashed with FNV-1a and divided down
// by the current branch ratio to predict the node level, and each result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module skiplist_height_checker import skl_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [SEQ_W-1:0]   sequence_number,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [LEVEL_W-1:0] node_level,
	input  wire logic               config_error,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [RATIO_W-1:0] cfg_data,
	output int                      mismatch_count,
	output int                      pending_count
);

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               err;
	} node_level_t;

	node_level_t        level_q[$];
	node_level_t        oldest;
	logic [LEVEL_W-1:0] height_limit;
	logic [RATIO_W-1:0] branch_ratio;
	int                 fails = 0;

	function automatic node_level_t level_from_sequence(
		input logic [SEQ_W-1:0]   seq,
		input logic [LEVEL_W-1:0] limit,
		input logic [RATIO_W-1:0] ratio
	);
		node_level_t        r;
		logic [HASH_W-1:0]  h;
		logic [LEVEL_W-1:0] lvl;
		r.level = '0;
		r.err   = 1'b1;
		if (limit == '0 || ratio < RATIO_MIN)
			return r;
		h = FNV_BASIS;
		for (int k = 0; k < 4; k++) begin
			h = h ^ {24'd0, seq[8*k +: 8]};
			h = h * FNV_PRIME;
		end
		lvl = 6'd1;
		while (lvl < limit && (h % ratio) == 0) begin
			lvl = lvl + 1'b1;
			h   = h / ratio;
		end
		r.level = lvl;
		r.err   = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q.delete();
			height_limit = LIMIT_RESET;
			branch_ratio = RATIO_RESET;
			pending_count  <= 0;
			mismatch_count <= fails;
		end else begin
			if (out_valid && out_ready) begin
				if (level_q.size() == 0) begin
					fails++;
					$display("%0t unexpected result: expected none, actual level %0d error %0b",
						$time, node_level, config_error);
				end else begin
					oldest = level_q.pop_front();
					if (node_level !== oldest.level) begin
						fails++;
						$display("%0t node_level: expected %0d, actual %0d",
							$time, oldest.level, node_level);
					end
					if (config_error !== oldest.err) begin
						fails++;
						$display("%0t config_error: expected %0b, actual %0b",
							$time, oldest.err, config_error);
					end
				end
			end
			if (in_valid && in_ready)
				level_q.push_back(level_from_sequence(sequence_number, height_limit,
					branch_ratio));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_IDX_LIMIT)
					height_limit = cfg_data[LEVEL_W-1:0];
				else
					branch_ratio = cfg_data;
			end
			pending_count  <= level_q.size();
			mismatch_count <= fails;
		end
	end

endmodule

// ===== bench/skiplist_height_from_hash_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skiplist_height_from_hash_core_tb: testbench top for the skip list level core
// Drives sequence numbers in random bursts, stalls the result side on its own
// pattern and rewrites the limit and ratio registers between idle phases,
// covering invalid settings and the extremes. The checker beside the core
// predicts every level and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module skiplist_height_from_hash_core_tb;
	import skl_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 64;

	logic               clk             = 1'b0;
	logic               arst_n          = 1'b0;
	logic               in_valid        = 1'b0;
	logic               in_ready;
	logic [SEQ_W-1:0]   sequence_number = '0;
	logic               out_valid;
	logic               out_ready       = 1'b0;
	logic [LEVEL_W-1:0] node_level;
	logic               config_error;
	logic               cfg_valid       = 1'b0;
	logic               cfg_ready;
	logic               cfg_index       = CFG_IDX_LIMIT;
	logic [RATIO_W-1:0] cfg_data        = '0;

	int mismatch_count;
	int pending_count;
	int cycles       = 0;
	int hold_asked   = 0;
	int hold_served  = 0;
	int burst_left   = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	skiplist_height_from_hash_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sequence_number (sequence_number),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.node_level      (node_level),
		.config_error    (config_error),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	skiplist_height_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sequence_number (sequence_number),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.node_level      (node_level),
		.config_error    (config_error),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.pending_count   (pending_count)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: random stall modes, plus long holds on request
	initial begin
		int mode;
		int stretch;
		mode    = 0;
		stretch = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_served < hold_asked) begin
				out_ready <= 1'b0;
				hold_served++;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (stretch == 0) begin
					mode    = $urandom_range(0, 2);
					stretch = $urandom_range(16, 200);
				end
				stretch--;
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic wait_for_results();
		while (pending_count != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [RATIO_W-1:0] data);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_one(input logic [SEQ_W-1:0] seq);
		in_valid        <= 1'b1;
		sequence_number <= seq;
		do
			@(posedge clk);
		while (!in_ready);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_run(input int n, input int gap_max);
		int gap;
		for (int i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				gap = $urandom_range(0, gap_max);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
			in_valid <= 1'b1;
			case ($urandom_range(0, 7))
				0:       sequence_number <= $urandom_range(0, 255);
				1:       sequence_number <= 32'hFFFF_FFFF ^ $urandom_range(0, 255);
				2:       sequence_number <= 32'd1 << $urandom_range(0, 31);
				default: sequence_number <= $urandom;
			endcase
			do
				@(posedge clk);
			while (!in_ready);
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [RATIO_W-1:0] lim;
		logic [RATIO_W-1:0] rat;
		int                 gap_max;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: limit 12, ratio 4
		send_one(32'h0000_0000);
		send_one(32'hFFFF_FFFF);
		send_one(32'h8000_0000);
		send_one(32'h0000_0001);
		send_one(32'hA5A5_A5A5);
		// zero limit
		write_reg(CFG_IDX_LIMIT, 8'd0);
		send_one(32'h1234_5678);
		send_one(32'hFFFF_FFFF);
		// ratio of zero and one
		write_reg(CFG_IDX_LIMIT, 8'd12);
		write_reg(CFG_IDX_RATIO, 8'd0);
		send_one(32'h0000_0000);
		send_one(32'hDEAD_BEEF);
		write_reg(CFG_IDX_RATIO, 8'd1);
		send_one(32'h5555_5555);
		// limit above 32, ratio 2
		write_reg(CFG_IDX_LIMIT, 8'd63);
		write_reg(CFG_IDX_RATIO, 8'd2);
		send_one($urandom);
		send_one($urandom);
		send_one(32'h0000_0100);
		// limit 32, ratio 255
		write_reg(CFG_IDX_LIMIT, 8'd32);
		write_reg(CFG_IDX_RATIO, 8'd255);
		send_one($urandom);
		send_one(32'h7FFF_FFFF);
		// limit 1
		write_reg(CFG_IDX_LIMIT, 8'd1);
		write_reg(CFG_IDX_RATIO, 8'd2);
		send_one(32'h0000_0000);
		send_one($urandom);
		// upper data bits are dropped from the limit
		write_reg(CFG_IDX_LIMIT, 8'hC7);
		write_reg(CFG_IDX_RATIO, 8'd3);
		send_one($urandom);
		send_one($urandom);

		for (int p = 0; p < 11; p++) begin
			case (p)
				0:       begin lim = 8'd12; rat = 8'd4;   end
				1:       begin lim = 8'd32; rat = 8'd2;   end
				2:       begin lim = 8'd63; rat = 8'd2;   end
				3:       begin lim = 8'd20; rat = 8'd3;   end
				4:       begin lim = 8'd0;  rat = 8'd4;   end
				5:       begin lim = 8'd5;  rat = 8'd1;   end
				6:       begin lim = 8'd32; rat = 8'd255; end
				7:       begin lim = 8'd2;  rat = 8'd16;  end
				default: begin
					lim = {2'($urandom_range(0, 3)), 6'($urandom_range(0, 63))};
					rat = 8'($urandom_range(0, 255));
				end
			endcase
			write_reg(CFG_IDX_LIMIT, lim);
			write_reg(CFG_IDX_RATIO, rat);
			gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 20);
			if (p == 3) begin
				hold_asked++;
				send_run(30, 0);
			end
			send_run(60, gap_max);
			wait_for_results();
			send_run(60, gap_max);
		end

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/skl_pkg.sv
rtl/skl_ctrl.sv
rtl/skl_dp.sv
rtl/skiplist_height_from_hash_core.sv
bench/skiplist_height_checker.sv
bench/skiplist_height_from_hash_core_tb.sv
